// ----- rtl/core/frws_pkg.sv -----
// Shared widths, codes and divider request/response types for the frame-rate statistics core.
`default_nettype none

package frws_pkg;

  // Window geometry.
  localparam int MAX_WINDOW = 128;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Field widths.
  localparam int RATE_W   = 18;
  localparam int PERIOD_W = 20;
  localparam int SUM_W    = 25;
  localparam int LEN_W    = 8;
  localparam int GRADE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Rate numerator: one second in microseconds, scaled to Q10.8.
  localparam int RATE_FRAC_BITS = 8;
  localparam int DVD_W  = 28;
  localparam int DSR_W  = PERIOD_W;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] RATE_DIVIDEND = DVD_W'(64'd1000000 << RATE_FRAC_BITS);
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OPTIMIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_EXCELLENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GOOD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FAIR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_POOR      = 3'd5;

  // Grade codes.
  localparam logic [GRADE_W-1:0] GRADE_EXCELLENT = 3'd0;
  localparam logic [GRADE_W-1:0] GRADE_GOOD      = 3'd1;
  localparam logic [GRADE_W-1:0] GRADE_FAIR      = 3'd2;
  localparam logic [GRADE_W-1:0] GRADE_POOR      = 3'd3;
  localparam logic [GRADE_W-1:0] GRADE_CRITICAL  = 3'd4;

  // Divider command: dividend is left aligned, steps is the number of quotient bits.
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/frws_cell.sv -----
// One cell of the sample ring: holds one rate sample and passes it to its neighbor.
`default_nettype none

module frws_cell (
  input  wire logic                        clk,
  input  wire logic                        shift,
  input  wire logic [frws_pkg::RATE_W-1:0] d,
  output logic      [frws_pkg::RATE_W-1:0] q
);

  // The sample moves one place along the ring on every scan cycle.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/frws_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by rate, pointer and average work.
`default_nettype none

module frws_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire frws_pkg::div_req_t req,
  output frws_pkg::div_rsp_t      rsp
);

  logic                          busy;
  logic [frws_pkg::STEP_W-1:0]   cnt;
  logic [frws_pkg::DVD_W-1:0]    dvd;
  logic [frws_pkg::DSR_W-1:0]    dsr;
  logic [frws_pkg::DSR_W-1:0]    rem;
  logic [frws_pkg::DVD_W-1:0]    quo;
  logic                          done;
  logic [frws_pkg::DSR_W+1:0]    trial;
  logic                          fits;

  // Trial subtract of the held divisor from the shifted partial remainder.
  always_comb begin
    trial = {1'b0, rem, dvd[frws_pkg::DVD_W-1]} - {2'b00, dsr};
    fits  = !trial[frws_pkg::DSR_W+1];
  end

  // Control: a step counter loaded from the request counts down while busy, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == frws_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: the divisor is captured at start, then one dividend bit and one
  // quotient bit are shifted per step.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[frws_pkg::DVD_W-2:0], 1'b0};
      rem <= fits ? trial[frws_pkg::DSR_W-1:0]
                  : {rem[frws_pkg::DSR_W-2:0], dvd[frws_pkg::DVD_W-1]};
      quo <= {quo[frws_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ----- rtl/core/frame_rate_window_stats_core.sv -----
// Top level of the frame-rate statistics core: control, sample ring and result register.
//
// Usage: each input beat on in_valid/in_ready carries one frame period in
// microseconds. The core turns it into a Q10.8 rate, writes it into a ring of
// 128 sample cells and returns one result beat on out_valid/out_ready with the
// current, average, minimum and maximum rate, the held period and the grade.
// Configuration beats on cfg_valid/cfg_ready are always taken; write them only
// while the core is idle.
// Sequence: the ring scan makes one rotation of the cell chain, then the PREP
// state sets up the average, the average division runs and the result is
// loaded. A nonzero period first adds a rate division and a full window a
// pointer wrap. One item is worked on at a time; the next beat is taken the
// cycle after the result is loaded.
// in_ready is high only while the core is idle. A finished result sits in the
// output register; the next item is accepted meanwhile and only waits at its
// very end if that register has not yet been taken.
// Reset clears the window (fill count, pointer, sum, last rate and period),
// restores the register defaults and drops out_valid.
`default_nettype none

module frame_rate_window_stats_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [frws_pkg::PERIOD_W-1:0]   frame_period_us,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [frws_pkg::RATE_W-1:0]     current_rate,
  output logic      [frws_pkg::RATE_W-1:0]     average_rate,
  output logic      [frws_pkg::RATE_W-1:0]     min_rate,
  output logic      [frws_pkg::RATE_W-1:0]     max_rate,
  output logic      [frws_pkg::PERIOD_W-1:0]   held_period_us,
  output logic      [frws_pkg::GRADE_W-1:0]    perf_grade,
  output logic                                 acceptable,
  output logic                                 optimize_request,
  // Configuration channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [frws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frws_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int N = frws_pkg::MAX_WINDOW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RATE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_AVG  = 3'd5;
  localparam logic [2:0] ST_LOAD = 3'd6;

  // Configuration registers.
  logic [frws_pkg::LEN_W-1:0]  window_len;
  logic                        auto_optimize;
  logic [frws_pkg::RATE_W-1:0] level_excellent;
  logic [frws_pkg::RATE_W-1:0] level_good;
  logic [frws_pkg::RATE_W-1:0] level_fair;
  logic [frws_pkg::RATE_W-1:0] level_poor;

  // Window state.
  logic [frws_pkg::PTR_W-1:0]    wp;
  logic [frws_pkg::CNT_W-1:0]    fill;
  logic [frws_pkg::SUM_W-1:0]    sum;
  logic [frws_pkg::RATE_W-1:0]   last_rate;
  logic [frws_pkg::PERIOD_W-1:0] last_period;

  // Per-item working registers.
  logic [2:0]                    state;
  logic [frws_pkg::PERIOD_W-1:0] period;
  logic [frws_pkg::RATE_W-1:0]   rate;
  logic                          append;
  logic [frws_pkg::PTR_W-1:0]    widx;
  logic [frws_pkg::PTR_W-1:0]    wp_wrap;
  logic [frws_pkg::PTR_W-1:0]    scan_idx;
  logic [frws_pkg::RATE_W-1:0]   mn;
  logic [frws_pkg::RATE_W-1:0]   mx;
  logic [frws_pkg::RATE_W-1:0]   avg;

  // Combinational helpers.
  logic [frws_pkg::CNT_W-1:0]  len_eff;
  logic                        append_now;
  logic [frws_pkg::CNT_W-1:0]  fill_new;
  logic [frws_pkg::RATE_W-1:0] head;
  logic [frws_pkg::RATE_W-1:0] scan_val;
  logic                        at_widx;
  logic                        go_rate;
  logic                        go_mod;
  logic                        go_avg;
  logic                        shift;
  logic                        load;
  logic [frws_pkg::GRADE_W-1:0] grade;

  frws_pkg::div_req_t div_req;
  frws_pkg::div_rsp_t div_rsp;

  logic [frws_pkg::RATE_W-1:0] ring_q [N];

  // Saturate a quotient to the largest rate value.
  function automatic logic [frws_pkg::RATE_W-1:0] sat_rate(
    input logic [frws_pkg::DVD_W-1:0] q
  );
    logic [frws_pkg::RATE_W-1:0] r;
    if (q > frws_pkg::DVD_W'(frws_pkg::RATE_MAX)) begin
      r = frws_pkg::RATE_MAX;
    end else begin
      r = q[frws_pkg::RATE_W-1:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // Configuration writes; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len      <= 8'd100;
      auto_optimize   <= 1'b1;
      level_excellent <= 18'd15360;
      level_good      <= 18'd11520;
      level_fair      <= 18'd7680;
      level_poor      <= 18'd3840;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        frws_pkg::REG_WINDOW_LEN:      window_len      <= cfg_data[frws_pkg::LEN_W-1:0];
        frws_pkg::REG_AUTO_OPTIMIZE:   auto_optimize   <= cfg_data[0];
        frws_pkg::REG_LEVEL_EXCELLENT: level_excellent <= cfg_data;
        frws_pkg::REG_LEVEL_GOOD:      level_good      <= cfg_data;
        frws_pkg::REG_LEVEL_FAIR:      level_fair      <= cfg_data;
        frws_pkg::REG_LEVEL_POOR:      level_poor      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective window length, clamped to one through the ring size.
  always_comb begin
    priority if (window_len == '0) begin
      len_eff = frws_pkg::CNT_W'(1);
    end else if (frws_pkg::CNT_W'(window_len) > frws_pkg::CNT_W'(N)) begin
      len_eff = frws_pkg::CNT_W'(N);
    end else begin
      len_eff = frws_pkg::CNT_W'(window_len);
    end
  end

  // Window bookkeeping and ring head.
  assign append_now = (fill < len_eff);
  assign fill_new   = append ? fill + 1'b1 : fill;
  assign head       = ring_q[0];
  assign at_widx    = (scan_idx == widx);
  assign scan_val   = at_widx ? rate : head;
  assign shift      = (state == ST_SCAN);

  // Divider launches.
  assign go_rate = (state == ST_IDLE) && in_valid && (frame_period_us != '0);
  assign go_mod  = ((state == ST_IDLE) && in_valid && (frame_period_us == '0) && !append_now)
                || ((state == ST_RATE) && div_rsp.done && !append);
  assign go_avg  = (state == ST_PREP);

  always_comb begin
    div_req.start    = go_rate || go_mod || go_avg;
    div_req.dividend = frws_pkg::RATE_DIVIDEND;
    div_req.divisor  = frame_period_us;
    div_req.steps    = frws_pkg::STEP_W'(frws_pkg::DVD_W);
    priority if (go_mod) begin
      div_req.dividend = {frws_pkg::LEN_W'(wp) + 1'b1, {frws_pkg::DVD_W-frws_pkg::LEN_W{1'b0}}};
      div_req.divisor  = frws_pkg::DSR_W'(len_eff);
      div_req.steps    = frws_pkg::STEP_W'(frws_pkg::LEN_W);
    end else if (go_avg) begin
      div_req.dividend = {sum, {frws_pkg::DVD_W-frws_pkg::SUM_W{1'b0}}};
      div_req.divisor  = frws_pkg::DSR_W'(fill_new);
      div_req.steps    = frws_pkg::STEP_W'(frws_pkg::SUM_W);
    end else begin
      div_req.dividend = frws_pkg::RATE_DIVIDEND;
      div_req.divisor  = frame_period_us;
      div_req.steps    = frws_pkg::STEP_W'(frws_pkg::DVD_W);
    end
  end

  frws_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sample ring: cell k takes from cell k+1; the last cell takes the head
  // value, replaced by the new rate when the write slot passes.
  for (genvar k = 0; k < N; k++) begin : g_ring
    if (k == N - 1) begin : g_tail
      frws_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (scan_val),
        .q     (ring_q[k])
      );
    end else begin : g_body
      frws_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (ring_q[k+1]),
        .q     (ring_q[k])
      );
    end
  end

  // Grade of the current rate; thresholds are tested in order.
  always_comb begin
    priority if (rate >= level_excellent) begin
      grade = frws_pkg::GRADE_EXCELLENT;
    end else if (rate >= level_good) begin
      grade = frws_pkg::GRADE_GOOD;
    end else if (rate >= level_fair) begin
      grade = frws_pkg::GRADE_FAIR;
    end else if (rate >= level_poor) begin
      grade = frws_pkg::GRADE_POOR;
    end else begin
      grade = frws_pkg::GRADE_CRITICAL;
    end
  end

  assign load = (state == ST_LOAD) && (!out_valid || out_ready);

  // Sequencer and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wp          <= '0;
      fill        <= '0;
      sum         <= '0;
      last_rate   <= '0;
      last_period <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (frame_period_us != '0) begin
              state <= ST_RATE;
            end else if (append_now) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_RATE: begin
          if (div_rsp.done) begin
            last_rate   <= sat_rate(div_rsp.quotient);
            last_period <= period;
            state       <= append ? ST_SCAN : ST_MOD;
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // The running sum adds the new sample and, once the window is full, drops the replaced one.
          if (at_widx) begin
            sum <= sum + frws_pkg::SUM_W'(rate) - (append ? '0 : frws_pkg::SUM_W'(head));
          end
          if (scan_idx == frws_pkg::PTR_W'(N - 1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          fill  <= fill_new;
          if (!append) begin
            wp <= wp_wrap;
          end
          state <= ST_AVG;
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-item datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      period   <= frame_period_us;
      rate     <= last_rate;
      append   <= append_now;
      widx     <= append_now ? fill[frws_pkg::PTR_W-1:0] : wp;
      scan_idx <= '0;
    end
    if (state == ST_RATE && div_rsp.done) begin
      rate <= sat_rate(div_rsp.quotient);
    end
    if (state == ST_MOD && div_rsp.done) begin
      wp_wrap <= div_rsp.remainder[frws_pkg::PTR_W-1:0];
    end
    if (state == ST_AVG && div_rsp.done) begin
      avg <= sat_rate(div_rsp.quotient);
    end
    // Minimum and maximum over the stored samples as they pass the head.
    if (shift) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_idx == '0) begin
        mn <= scan_val;
        mx <= scan_val;
      end else if (frws_pkg::CNT_W'(scan_idx) < fill_new) begin
        if (scan_val < mn) begin
          mn <= scan_val;
        end
        if (scan_val > mx) begin
          mx <= scan_val;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      current_rate     <= rate;
      average_rate     <= avg;
      min_rate         <= mn;
      max_rate         <= mx;
      held_period_us   <= last_period;
      perf_grade       <= grade;
      acceptable       <= (grade == frws_pkg::GRADE_EXCELLENT) || (grade == frws_pkg::GRADE_GOOD)
                       || (grade == frws_pkg::GRADE_FAIR);
      optimize_request <= (grade == frws_pkg::GRADE_CRITICAL) && auto_optimize;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/frws_checker.sv -----
// Port-level checks for the frame-rate statistics core, bound to the top level.
`default_nettype none

module frws_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [frws_pkg::RATE_W-1:0]     average_rate,
  input wire logic [frws_pkg::RATE_W-1:0]     min_rate,
  input wire logic [frws_pkg::RATE_W-1:0]     max_rate,
  input wire logic [frws_pkg::GRADE_W-1:0]    perf_grade,
  input wire logic                            acceptable,
  input wire logic                            optimize_request
);

  // A stalled result beat stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // One item at a time: the core is busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // The average lies between the window minimum and maximum.
  a_stats_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_rate <= average_rate) && (average_rate <= max_rate))
    else $error("average outside minimum and maximum");

  // Status flags agree with the grade.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (acceptable == (perf_grade <= frws_pkg::GRADE_FAIR))
               && (!optimize_request || (perf_grade == frws_pkg::GRADE_CRITICAL)))
    else $error("status flags disagree with grade");

endmodule

bind frame_rate_window_stats_core frws_checker u_frws_checker (.*);

`default_nettype wire
